FILE: rtl/flt_pkg.sv
// flt_pkg: shared types and constants of the file lock table
// transaction structs, lock and status codes, slot sizing
// no dependencies
package flt_pkg;

    localparam int LOCK_SLOTS  = 32;
    localparam int SLOT_W      = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
    localparam int INDEX_OUT_W = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // request kind codes on the input
    localparam logic REQ_LOCK   = 1'b0;
    localparam logic REQ_UNLOCK = 1'b1;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    typedef enum logic [1:0] {
        LK_NONE  = 2'd0,
        LK_READ  = 2'd1,
        LK_WRITE = 2'd2
    } t_lock;

    typedef enum logic [2:0] {
        RS_DONE      = 3'd0,
        RS_CONFLICT  = 3'd1,
        RS_FULL      = 3'd2,
        RS_BADKIND   = 3'd3,
        RS_COUNTFULL = 3'd4
    } t_status;

    typedef struct packed {
        logic               req_type;
        logic [15:0]        file_number;
        logic [1:0]         lock_kind;
        logic signed [15:0] user_id;
    } t_in_item;

    typedef struct packed {
        t_status                  status;
        logic                     slot_found;
        logic [INDEX_OUT_W-1:0]   slot_index;
    } t_out_item;

    // classified request handed from front to back
    typedef struct packed {
        logic        is_unlock;
        logic        kind_rd;
        logic        kind_wr;
        logic [15:0] file_number;
        logic [15:0] user_id;
    } t_op;

    // queue occupancy seen by producer and consumer
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

FILE: rtl/flt_front.sv
// flt_front: input register that accepts and classifies lock transactions
// depends on flt_pkg; feeds flt_queue
module flt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  flt_pkg::t_in_item i_in_data,
    output logic              o_in_stall,
    input  flt_pkg::t_q_stat  i_q_stat,
    output logic              o_push,
    output flt_pkg::t_op      o_op
);
    import flt_pkg::*;

    logic r_valid, n_valid;
    t_op  r_op, n_op;
    logic accept;

    // hold while the queue cannot take the held transaction
    assign o_in_stall = r_valid && i_q_stat.full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_valid && !i_q_stat.full;
    assign o_op       = r_op;

    // decode request type and lock kind
    always_comb begin
        n_op.is_unlock   = (i_in_data.req_type == REQ_UNLOCK);
        n_op.kind_rd     = (i_in_data.lock_kind == KIND_READ);
        n_op.kind_wr     = (i_in_data.lock_kind == KIND_WRITE);
        n_op.file_number = i_in_data.file_number;
        n_op.user_id     = i_in_data.user_id;
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= n_op;
        end
    end

endmodule

FILE: rtl/flt_queue.sv
// flt_queue: short fifo of classified requests between front and back
// depends on flt_pkg
module flt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  flt_pkg::t_op     i_op,
    input  logic             i_pop,
    output flt_pkg::t_op     o_head,
    output flt_pkg::t_q_stat o_stat
);
    import flt_pkg::*;

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_push, do_pop;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    // occupancy never exceeds the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

    // a push into a full queue leaves the count unchanged unless popped
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stat.full && !i_pop) |=> r_count == QCNT_W'(QUEUE_DEPTH))
        else $error("full queue lost an entry");

    // a pop with a push keeps the count
    a_pushpop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && do_pop) |=> $stable(r_count))
        else $error("simultaneous push and pop changed occupancy");

endmodule

FILE: rtl/flt_back.sv
// flt_back: slot table, lookup and lock read-modify-write, result register
// depends on flt_pkg; pops flt_queue
module flt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  flt_pkg::t_op       i_head,
    input  flt_pkg::t_q_stat   i_q_stat,
    output logic               o_pop,
    output logic               o_out_valid,
    output flt_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import flt_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [15:0] file;
        t_lock       state;
        logic [15:0] owner;
        logic [7:0]  readers;
    } t_slot;

    localparam t_slot SLOT_FREE = '{file: 16'h0000, state: LK_NONE,
                                    owner: 16'hFFFF, readers: 8'h00};
    localparam logic [7:0] READERS_MAX = 8'hFF;

    t_state            r_state;
    t_slot             r_slot [LOCK_SLOTS];
    t_op               r_op;
    logic [SLOT_W-1:0] r_idx;
    logic              r_found;
    logic              r_take;
    logic              r_out_valid;
    t_out_item         r_out;

    logic [LOCK_SLOTS-1:0] match_vec, free_vec;
    logic [SLOT_W-1:0]     hit_idx, free_idx;
    logic                  hit_any, free_any;
    logic [SLOT_W-1:0]     n_idx;
    logic                  n_found, n_take;
    logic                  exec_go;
    t_slot                 cur, nxt;
    t_status               res_status;
    t_out_item             n_out;
    logic [SLOT_W+INDEX_OUT_W-1:0] idx_wide;

    assign o_pop       = (r_state == S_IDLE) && !i_q_stat.empty;
    assign exec_go     = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // parallel compare of the head file number and of free slots
    always_comb begin
        for (int i = 0; i < LOCK_SLOTS; i++) begin
            match_vec[i] = (r_slot[i].file == i_head.file_number);
            free_vec[i]  = (r_slot[i].file == 16'h0000);
        end
    end

    // lowest matching and lowest free slot
    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = LOCK_SLOTS - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                hit_idx = SLOT_W'(i);
            end
            if (free_vec[i]) begin
                free_idx = SLOT_W'(i);
            end
        end
        hit_any  = |match_vec;
        free_any = |free_vec;
    end

    // slot choice: unlock only uses a match, lock may take a free slot
    always_comb begin
        n_take  = !i_head.is_unlock && !hit_any && free_any;
        n_found = hit_any || n_take;
        n_idx   = hit_any ? hit_idx : free_idx;
    end

    // lock decision on the chosen slot
    always_comb begin
        cur = r_slot[r_idx];
        if (r_take) begin
            cur.file    = r_op.file_number;
            cur.state   = LK_NONE;
            cur.readers = 8'h00;
        end
        nxt        = cur;
        res_status = RS_DONE;
        if (!r_found) begin
            if (!r_op.is_unlock) begin
                res_status = RS_FULL;
            end else if (!r_op.kind_rd && !r_op.kind_wr) begin
                res_status = RS_BADKIND;
            end
        end else if (!r_op.is_unlock) begin
            priority if (r_op.kind_rd) begin
                if (cur.state == LK_WRITE && cur.owner != r_op.user_id) begin
                    res_status = RS_CONFLICT;
                end else if (cur.readers == READERS_MAX) begin
                    res_status = RS_COUNTFULL;
                end else begin
                    nxt.readers = cur.readers + 8'd1;
                    nxt.state   = LK_READ;
                    nxt.owner   = r_op.user_id;
                end
            end else if (r_op.kind_wr) begin
                if (cur.state != LK_NONE && (cur.owner != r_op.user_id ||
                    (cur.state == LK_READ && cur.readers > 8'd1))) begin
                    res_status = RS_CONFLICT;
                end else begin
                    nxt.state   = LK_WRITE;
                    nxt.owner   = r_op.user_id;
                    nxt.readers = 8'h00;
                end
            end else begin
                res_status = RS_BADKIND;
            end
        end else begin
            priority if (r_op.kind_rd) begin
                if (cur.readers != 8'h00) begin
                    nxt.readers = cur.readers - 8'd1;
                    if (cur.readers == 8'd1) begin
                        nxt = SLOT_FREE;
                    end
                end
            end else if (r_op.kind_wr) begin
                nxt = SLOT_FREE;
            end else begin
                res_status = RS_BADKIND;
            end
        end
    end

    // result transaction
    always_comb begin
        idx_wide         = {{INDEX_OUT_W{1'b0}}, r_idx};
        n_out.status     = res_status;
        n_out.slot_found = r_found;
        n_out.slot_index = r_found ? idx_wide[INDEX_OUT_W-1:0] : '0;
    end

    // sequencer, table and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < LOCK_SLOTS; i++) begin
                r_slot[i] <= SLOT_FREE;
            end
        end else begin
            // load on execution, drop once the result is taken
            if (exec_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_go) begin
                        r_state <= S_IDLE;
                        if (r_found) begin
                            r_slot[r_idx] <= nxt;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_op    <= i_head;
            r_idx   <= n_idx;
            r_found <= n_found;
            r_take  <= n_take;
        end
        if (exec_go) begin
            r_out <= n_out;
        end
    end

    // execution always follows a pop
    a_exec_after_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == S_EXEC) |-> $past(o_pop))
        else $error("execute entered without a pop");

    // the chosen slot holds the file number or is free
    a_slot_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_found) |->
            (r_slot[r_idx].file == r_op.file_number || r_slot[r_idx].file == 16'h0000))
        else $error("chosen slot does not fit the request");

    // a new result only comes out of execution
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(exec_go))
        else $error("result without execution");

    // table full only reported when no slot was found
    a_full_unfound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_go && res_status == RS_FULL) |-> !r_found)
        else $error("table full with a slot found");

endmodule

FILE: rtl/file_lock_table.sv
// file_lock_table: top level of the reader/writer file lock table
// depends on flt_pkg, flt_front, flt_queue, flt_back
//
// Lock and unlock transactions enter through a front register that decodes
// them into a two-entry queue; the back end pops one request, compares its
// file number against every slot and picks the lowest match or free slot in
// that cycle, then reads, updates and writes the slot in its execute state,
// loading the result register; a stalled output can hold the execute state.
// The back end pops no new request until it has executed the last one. A
// request passes the front register, the queue, the pop and the execute
// state before its result is valid on the output. The result register lets
// the queue keep filling while a result waits. Reset clears all slots at
// once, so no clearing pass is needed.
module file_lock_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  flt_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output flt_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import flt_pkg::*;

    t_op     push_op, head_op;
    t_q_stat q_stat;
    logic    push, pop;

    // accept and classify
    flt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_stat   (q_stat),
        .o_push     (push),
        .o_op       (push_op)
    );

    // request queue
    flt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_pop   (pop),
        .o_head  (head_op),
        .o_stat  (q_stat)
    );

    // slot table and execution
    flt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_op),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
